[sv/bcrc_pkg.sv]
// Package for the BLE CRC-24 reverse runner.
// Holds the LFSR constants and the byte step / bit flip functions.
// No dependencies.
`timescale 1ns / 1ps

package bcrc_pkg;

	localparam int unsigned CRC_W = 24;
	localparam int unsigned BYTE_W = 8;
	localparam logic [CRC_W-1:0] TAP_MASK = 24'hB4C000;

	typedef logic [CRC_W-1:0] crc_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Eight reverse LFSR steps, data MSB first.
	function automatic crc_t run_byte(crc_t reg_in, byte_t data);
		crc_t r;
		logic top;
		r = reg_in;
		for (int k = 0; k < BYTE_W; k++) begin
			top = r[CRC_W-1];
			r = {r[CRC_W-2:0], top ^ data[BYTE_W-1-k]};
			if (top) begin
				r = r ^ TAP_MASK;
			end
		end
		return r;
	endfunction

	function automatic crc_t flip_crc(crc_t v);
		crc_t r;
		for (int i = 0; i < CRC_W; i++) begin
			r[CRC_W-1-i] = v[i];
		end
		return r;
	endfunction

endpackage

[sv/ble_crc24_reverse_init.sv]
// BLE CRC-24 reverse runner: recovers the CRC initial value of a packet.
//
// Usage: feed packet bytes last byte first on the item channel
// (item_valid / item_stall). The item marked first_byte loads received_crc
// into the register before its byte is run; bytes without it continue from
// the current register. The item marked last_byte yields one result on the
// result channel (result_valid / result_stall): the register bit-reversed.
// The register is never cleared between packets.
//
// Throughput: one item per cycle unless a last item waits in the input stage
// (see Stall). Each item is registered at the input, then its eight LFSR
// steps run in one combinational pass into the register and the result
// register. A result is loaded when its last item leaves the input stage.
// Stall: while a result waits under result_stall, non-last items keep
// flowing; a last item holds in the input stage and item_stall rises.
// Reset: arst_n clears the register to zero and empties both stages.
// Depends on bcrc_pkg.
`timescale 1ns / 1ps

module ble_crc24_reverse_init (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  bcrc_pkg::byte_t      data_byte,
	input  bcrc_pkg::crc_t       received_crc,
	input  logic                 first_byte,
	input  logic                 last_byte,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bcrc_pkg::crc_t       crc_init
);
	import bcrc_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;
	crc_t  crc_s1;
	logic  first_s1;
	logic  last_s1;

	crc_t  lfsr_q;
	logic  result_valid_q;
	crc_t  crc_init_q;

	crc_t  lfsr_next;
	logic  retire;
	logic  slot_free;

	assign slot_free  = !result_valid_q || !result_stall;
	assign retire     = valid_s1 && (!last_s1 || slot_free);
	assign item_stall = valid_s1 && !retire;
	assign lfsr_next  = run_byte(first_s1 ? crc_s1 : lfsr_q, byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			byte_s1  <= data_byte;
			crc_s1   <= received_crc;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= '0;
		end else if (retire) begin
			lfsr_q <= lfsr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (retire && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && last_s1) begin
			crc_init_q <= flip_crc(lfsr_next);
		end
	end

	assign result_valid = result_valid_q;
	assign crc_init     = crc_init_q;

	// A last item must not overwrite a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && result_valid_q && result_stall) |-> item_stall)
		else $error("last item retired over a stalled result");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> valid_s1)
		else $error("accepted item missing from input stage");

	a_lfsr_update: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> (lfsr_q == $past(lfsr_next)))
		else $error("register not updated by retired item");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && last_s1) |=> (result_valid && crc_init == flip_crc($past(lfsr_next))))
		else $error("result not loaded for last item");

endmodule

[tb/ble_crc24_reverse_init_tb.sv]
// Testbench for ble_crc24_reverse_init: directed and random packets, checked by a scoreboard.
// The scoreboard runs its own reverse CRC-24 over each accepted item.
// Depends on bcrc_pkg and the ble_crc24_reverse_init RTL.
`timescale 1ns / 1ps

module ble_crc24_reverse_init_tb;

	import bcrc_pkg::*;

	localparam crc_t REV_POLY = 24'hB4C000;
	localparam int   ITEM_TARGET = 900;

	class crc_init_board;
		crc_t lfsr;
		crc_t init_q[$];
		int   errors;
		int   items;
		int   results;

		function new();
			lfsr = '0;
			errors = 0;
			items = 0;
			results = 0;
		endfunction

		// Run the register backwards over one byte, data MSB first.
		function crc_t unwind_byte(crc_t r, byte_t d);
			logic top;
			for (int b = 7; b >= 0; b--) begin
				top = r[23];
				r = (r << 1) | crc_t'(top ^ d[b]);
				if (top) begin
					r ^= REV_POLY;
				end
			end
			return r;
		endfunction

		function crc_t mirror24(crc_t v);
			crc_t m;
			m = '0;
			for (int i = 0; i < 24; i++) begin
				m = (m << 1) | crc_t'(v[i]);
			end
			return m;
		endfunction

		function void note_item(byte_t d, crc_t rx_crc, logic first, logic last);
			crc_t r;
			r = first ? rx_crc : lfsr;
			lfsr = unwind_byte(r, d);
			items++;
			if (last) begin
				init_q.push_back(mirror24(lfsr));
			end
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(crc_t got);
			crc_t want;
			results++;
			if (init_q.size() == 0) begin
				report($sformatf("unexpected crc_init %06h", got));
			end else begin
				want = init_q.pop_front();
				if (got !== want) begin
					report($sformatf("crc_init %06h, expected %06h", got, want));
				end
			end
		endtask

		task flush_check();
			while (init_q.size() > 0) begin
				report($sformatf("missing crc_init %06h", init_q.pop_front()));
			end
		endtask
	endclass

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	byte_t data_byte;
	crc_t  received_crc;
	logic  first_byte;
	logic  last_byte;
	logic  result_valid;
	logic  result_stall = 1'b0;
	crc_t  crc_init;

	crc_init_board sb;
	bit tx_calm;
	bit rx_calm;
	int sent;
	int packets;
	int stall_left = 0;

	ble_crc24_reverse_init dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.data_byte(data_byte),
		.received_crc(received_crc),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.crc_init(crc_init)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly zero, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			sb.note_item(data_byte, received_crc, first_byte, last_byte);
		end
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(crc_init);
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else begin
			result_stall <= !rx_calm && ($urandom_range(0, 2) == 0);
			stall_left = pick_gap();
		end
	end

	task automatic push_item(input byte_t d, input crc_t c, input logic f, input logic l);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		data_byte <= d;
		received_crc <= c;
		first_byte <= f;
		last_byte <= l;
		do @(posedge clk); while (item_stall);
		sent++;
	endtask

	task automatic push_packet(input int len);
		crc_t c;
		c = crc_t'($urandom());
		for (int i = 0; i < len; i++) begin
			push_item(byte_t'($urandom()), c, i == 0, i == len - 1);
		end
		packets++;
	endtask

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int r;
		int len;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		data_byte = '0;
		received_crc = '0;
		first_byte = 1'b0;
		last_byte = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		sent = 0;
		packets = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// no first item since reset: runs from the cleared register
		push_item(8'hA5, 24'h123456, 1'b0, 1'b1);
		// single-byte packets at the field extremes
		push_item(8'h00, 24'h000000, 1'b1, 1'b1);
		push_item(8'hFF, 24'hFFFFFF, 1'b1, 1'b1);
		push_item(8'h80, 24'h800000, 1'b1, 1'b1);
		push_item(8'h01, 24'h000001, 1'b1, 1'b1);
		// register kept after a result
		push_item(8'h3C, 24'hABCDEF, 1'b0, 1'b1);
		push_item(8'hC3, 24'h000000, 1'b0, 1'b1);
		// multi-byte packet
		push_item(8'h00, 24'h555555, 1'b1, 1'b0);
		push_item(8'hAA, 24'hFFFFFF, 1'b0, 1'b0);
		push_item(8'h55, 24'h000000, 1'b0, 1'b0);
		push_item(8'hFF, 24'hAAAAAA, 1'b0, 1'b1);
		// reload in the middle of a packet
		push_item(8'h12, 24'h0F0F0F, 1'b1, 1'b0);
		push_item(8'h34, 24'hF0F0F0, 1'b1, 1'b0);
		push_item(8'h56, 24'h000000, 1'b0, 1'b1);
		// bytes with neither flag
		push_item(8'h7F, 24'hFFFFFF, 1'b0, 1'b0);
		push_item(8'hFE, 24'h800001, 1'b0, 1'b0);
		push_item(8'h99, 24'h000000, 1'b0, 1'b1);
		packets += 10;

		while (sent < ITEM_TARGET) begin
			case ((sent / 150) % 3)
				0: begin tx_calm = 1'b0; rx_calm = 1'b0; end
				1: begin tx_calm = 1'b1; rx_calm = 1'b1; end
				default: begin tx_calm = 1'b1; rx_calm = 1'b0; end
			endcase
			r = $urandom_range(0, 99);
			if (r < 85) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				push_packet(len);
			end else begin
				// loose items with random flags
				len = $urandom_range(1, 5);
				repeat (len) begin
					push_item(byte_t'($urandom()), crc_t'($urandom()),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;
		rx_calm = 1'b0;

		for (int w = 0; w < 5000 && sb.init_q.size() > 0; w++) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		sb.flush_check();

		$display("Sent %0d items (%0d packets), checked %0d crc_init results.",
			sb.items, packets, sb.results);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
